// ----- rtl/svf_pkg.sv -----
// svf_pkg: shared types, constants and helpers of the Q1.31 state-variable filter
// holds register indexes, mode codes, the microcode word layout and the saturation helper
// no dependencies
package svf_pkg;

    // register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOTCH_GAIN = 3'd6;

    // output mode codes
    localparam logic [2:0] MODE_HIGH = 3'd0;
    localparam logic [2:0] MODE_BAND = 3'd1;
    localparam logic [2:0] MODE_LOW = 3'd2;
    localparam logic [2:0] MODE_NOTCH = 3'd3;
    localparam logic [2:0] MODE_MIX = 3'd4;

    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    // microcode step address
    typedef logic [3:0] step_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MP_NONE,
        MP_F_BAND,
        MP_MANT_BAND,
        MP_F_HIGH,
        MP_LOW_LG,
        MP_HIGH_HG,
        MP_BAND_BG,
        MP_TMP_NG
    } mul_pair_t;

    typedef enum logic [2:0] {
        A_ZERO,
        A_LOW,
        A_BAND,
        A_TMP,
        A_X,
        A_ACC,
        A_HALF
    } alu_a_t;

    typedef enum logic [2:0] {
        B_Q,
        B_QSH,
        B_LOW,
        B_HIGH,
        B_ACCH
    } alu_b_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_LOW,
        D_BAND,
        D_HIGH,
        D_TMP,
        D_ACC,
        D_HALF,
        D_OUT,
        D_OUTSEL
    } dst_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_ALWAYS,
        C_MIX,
        C_PASS
    } cond_t;

    // one control word of the program
    typedef struct packed {
        mul_pair_t mul;
        alu_a_t    a;
        alu_b_t    b;
        logic      sub;
        dst_t      dst;
        cond_t     cond;
        step_t     target;
        logic      set_pass;
        logic      done;
    } ucode_t;

    // saturate a 33 bit signed value to Q1.31
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q31_MIN : Q31_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/state_variable_filter_q31.sv -----
// state_variable_filter_q31: top level of the Q1.31 Chamberlin state-variable filter
// depends on svf_pkg, svf_norm, svf_seq and svf_datapath
//
// One sample in, one filtered sample out. A microcoded sequencer runs every sample through
// one shared 32x32 multiplier and one saturating adder, one control step per cycle while the
// finishing step is not held by a full output register. Modes high, band, low and notch run
// one frame per sample; the oversampled mix runs the frame and the four weighted products
// twice. A new sample is taken only once the sequencer has finished the last one. A finished
// result sits in the output register while the next sample is already being worked on.
// A write to the damping register is normalised one bit per cycle and holds s_tready low.
module state_variable_filter_q31
    import svf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    // input samples
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] sample_in
    // filtered samples
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [31:0] sample_out
);

    logic [30:0]        damp_mant;
    logic [4:0]         damp_shift;
    logic               norm_busy;
    logic               seq_busy;
    logic               start;
    logic               fire;
    logic               mix_mode;
    logic               out_blocked;
    ucode_t             ctl;
    logic signed [31:0] sample_out;

    // accept a transaction when sequencer and normaliser are both idle
    assign s_tready = !seq_busy && !norm_busy;
    assign start = s_tvalid && s_tready;

    svf_norm u_norm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .damp_mant  (damp_mant),
        .damp_shift (damp_shift),
        .busy       (norm_busy)
    );

    svf_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .mix_mode    (mix_mode),
        .out_blocked (out_blocked),
        .ctl         (ctl),
        .fire        (fire),
        .busy        (seq_busy)
    );

    svf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .damp_mant   (damp_mant),
        .damp_shift  (damp_shift),
        .start       (start),
        .sample_in   (s_tdata),
        .ctl         (ctl),
        .fire        (fire),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_blocked (out_blocked),
        .mix_mode    (mix_mode),
        .sample_out  (sample_out)
    );

    assign m_tdata = sample_out;

endmodule

// ----- rtl/svf_norm.sv -----
// svf_norm: normalises the damping register into mantissa and shift, one bit a cycle
// depends on svf_pkg
module svf_norm
    import svf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    output logic [30:0]          damp_mant,
    output logic [4:0]           damp_shift,
    output logic                 busy
);

    logic [30:0] mant_reg, mant_next;
    logic [4:0]  shift_reg, shift_next;
    logic        busy_reg, busy_next;

    // load on a write, then shift left until bit 30 is set
    always_comb begin
        mant_next = mant_reg;
        shift_next = shift_reg;
        busy_next = busy_reg;
        if (cfg_we && cfg_index == REG_DAMPING) begin
            mant_next = cfg_wdata[30:0];
            shift_next = '0;
            busy_next = (cfg_wdata[30:0] != '0) && !cfg_wdata[30];
        end else if (busy_reg) begin
            mant_next = {mant_reg[29:0], 1'b0};
            shift_next = shift_reg + 5'd1;
            busy_next = !mant_reg[29];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mant_reg <= '0;
            shift_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            mant_reg <= mant_next;
            shift_reg <= shift_next;
            busy_reg <= busy_next;
        end
    end

    assign damp_mant = mant_reg;
    assign damp_shift = shift_reg;
    assign busy = busy_reg;

endmodule

// ----- rtl/svf_seq.sv -----
// svf_seq: microcode sequencer with the program table, step counter and branch logic
// depends on svf_pkg
module svf_seq
    import svf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  logic   mix_mode,
    input  logic   out_blocked,
    output ucode_t ctl,
    output logic   fire,
    output logic   busy
);

    localparam step_t L_FRAME = 4'd0;
    localparam step_t L_MIX = 4'd7;
    localparam step_t L_FINAL = 4'd14;
    localparam step_t L_LAST = 4'd14;

    logic  busy_reg, busy_next;
    step_t pc_reg, pc_next;
    logic  pass_reg, pass_next;
    logic  taken;
    logic  stall;

    // program: one frame, then either the plain output or the weighted mix, which runs the frame twice
    always_comb begin
        ctl = '{MP_NONE, A_ZERO, B_Q, 1'b0, D_NONE, C_NONE, L_FRAME, 1'b0, 1'b1};
        unique case (pc_reg)
            4'd0: ctl = '{MP_F_BAND, A_ZERO, B_Q, 1'b0, D_NONE, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd1: ctl = '{MP_MANT_BAND, A_LOW, B_Q, 1'b0, D_LOW, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd2: ctl = '{MP_NONE, A_X, B_QSH, 1'b1, D_TMP, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd3: ctl = '{MP_NONE, A_TMP, B_LOW, 1'b1, D_HIGH, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd4: ctl = '{MP_F_HIGH, A_ZERO, B_Q, 1'b0, D_NONE, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd5: ctl = '{MP_NONE, A_BAND, B_Q, 1'b0, D_BAND, C_MIX, L_MIX, 1'b0, 1'b0};
            4'd6: ctl = '{MP_NONE, A_LOW, B_HIGH, 1'b0, D_OUTSEL, C_NONE, L_FRAME, 1'b0, 1'b1};
            4'd7: ctl = '{MP_LOW_LG, A_LOW, B_HIGH, 1'b0, D_TMP, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd8: ctl = '{MP_HIGH_HG, A_ZERO, B_Q, 1'b0, D_ACC, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd9: ctl = '{MP_BAND_BG, A_ACC, B_Q, 1'b0, D_ACC, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd10: ctl = '{MP_TMP_NG, A_ACC, B_Q, 1'b0, D_ACC, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd11: ctl = '{MP_NONE, A_ACC, B_Q, 1'b0, D_ACC, C_NONE, L_FRAME, 1'b0, 1'b0};
            4'd12: ctl = '{MP_NONE, A_ZERO, B_Q, 1'b0, D_NONE, C_PASS, L_FINAL, 1'b0, 1'b0};
            4'd13: ctl = '{MP_NONE, A_ZERO, B_ACCH, 1'b0, D_HALF, C_ALWAYS, L_FRAME, 1'b1, 1'b0};
            4'd14: ctl = '{MP_NONE, A_HALF, B_ACCH, 1'b0, D_OUT, C_NONE, L_FRAME, 1'b0, 1'b1};
            default: ctl = '{MP_NONE, A_ZERO, B_Q, 1'b0, D_NONE, C_NONE, L_FRAME, 1'b0, 1'b1};
        endcase
    end

    // branch condition
    always_comb begin
        unique case (ctl.cond)
            C_NONE: taken = 1'b0;
            C_ALWAYS: taken = 1'b1;
            C_MIX: taken = mix_mode;
            C_PASS: taken = pass_reg;
            default: taken = 1'b0;
        endcase
    end

    // a finishing step waits while the output register is still full
    assign stall = ctl.done && out_blocked;
    assign fire = busy_reg && !stall;

    always_comb begin
        busy_next = busy_reg;
        pc_next = pc_reg;
        pass_next = pass_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next = L_FRAME;
            pass_next = 1'b0;
        end else if (fire) begin
            if (ctl.done) begin
                busy_next = 1'b0;
            end else if (taken) begin
                pc_next = ctl.target;
            end else begin
                pc_next = pc_reg + 4'd1;
            end
            if (ctl.set_pass) begin
                pass_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg <= L_FRAME;
            pass_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pc_reg <= pc_next;
            pass_reg <= pass_next;
        end
    end

    assign busy = busy_reg;

    // a new transaction only starts on an idle sequencer
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("start while busy");

    // the step counter stays inside the program
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= L_LAST) else $error("step counter out of program");

    // a stalled finishing step keeps its place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && stall) |=> (busy_reg && $stable(pc_reg)))
        else $error("stalled step lost");

    // the second pass only happens in mix mode
    a_pass_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && pass_reg) |-> mix_mode) else $error("second pass outside mix mode");

endmodule

// ----- rtl/svf_datapath.sv -----
// svf_datapath: configuration registers, shared multiplier, saturating adder and state
// depends on svf_pkg; driven by the control word of svf_seq
module svf_datapath
    import svf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic [30:0]          damp_mant,
    input  logic [4:0]           damp_shift,
    input  logic                 start,
    input  logic signed [31:0]   sample_in,
    input  ucode_t               ctl,
    input  logic                 fire,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_blocked,
    output logic                 mix_mode,
    output logic signed [31:0]   sample_out
);

    logic [30:0]        cutoff_reg;
    logic [2:0]         mode_reg;
    logic signed [31:0] low_gain_reg, high_gain_reg, band_gain_reg, notch_gain_reg;
    logic signed [31:0] low_reg, band_reg, high_reg, tmp_reg, acc_reg, half_reg, x_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] out_reg;
    logic               out_valid_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] q, qsh, acch;
    logic signed [31:0] op_a, op_b;
    logic signed [32:0] sum;
    logic signed [31:0] alu_res;
    logic signed [31:0] outsel;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= '0;
            mode_reg <= MODE_HIGH;
            low_gain_reg <= '0;
            high_gain_reg <= '0;
            band_gain_reg <= '0;
            notch_gain_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CUTOFF: cutoff_reg <= cfg_wdata[30:0];
                REG_MODE: mode_reg <= cfg_wdata[2:0];
                REG_LOW_GAIN: low_gain_reg <= cfg_wdata;
                REG_HIGH_GAIN: high_gain_reg <= cfg_wdata;
                REG_BAND_GAIN: band_gain_reg <= cfg_wdata;
                REG_NOTCH_GAIN: notch_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // multiplier operand pairs
    always_comb begin
        unique case (ctl.mul)
            MP_F_BAND: begin mul_a = {1'b0, cutoff_reg}; mul_b = band_reg; end
            MP_MANT_BAND: begin mul_a = {1'b0, damp_mant}; mul_b = band_reg; end
            MP_F_HIGH: begin mul_a = {1'b0, cutoff_reg}; mul_b = high_reg; end
            MP_LOW_LG: begin mul_a = low_reg; mul_b = low_gain_reg; end
            MP_HIGH_HG: begin mul_a = high_reg; mul_b = high_gain_reg; end
            MP_BAND_BG: begin mul_a = band_reg; mul_b = band_gain_reg; end
            MP_TMP_NG: begin mul_a = tmp_reg; mul_b = notch_gain_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (fire && ctl.mul != MP_NONE) begin
            prod_reg <= prod_next;
        end
    end

    // q1.31 product with floor and saturation, plus the damped and halved forms
    assign q = sat33(prod_reg[63:31]);
    assign qsh = q >>> damp_shift;
    assign acch = acc_reg >>> 1;

    // saturating adder
    always_comb begin
        unique case (ctl.a)
            A_ZERO: op_a = '0;
            A_LOW: op_a = low_reg;
            A_BAND: op_a = band_reg;
            A_TMP: op_a = tmp_reg;
            A_X: op_a = x_reg;
            A_ACC: op_a = acc_reg;
            A_HALF: op_a = half_reg;
            default: op_a = '0;
        endcase
        unique case (ctl.b)
            B_Q: op_b = q;
            B_QSH: op_b = qsh;
            B_LOW: op_b = low_reg;
            B_HIGH: op_b = high_reg;
            B_ACCH: op_b = acch;
            default: op_b = '0;
        endcase
    end

    assign sum = ctl.sub ? ({op_a[31], op_a} - {op_b[31], op_b})
                         : ({op_a[31], op_a} + {op_b[31], op_b});
    assign alu_res = sat33(sum);

    // single frame result by mode, unused modes give zero
    always_comb begin
        unique case (mode_reg)
            MODE_HIGH: outsel = high_reg;
            MODE_BAND: outsel = band_reg;
            MODE_LOW: outsel = low_reg;
            MODE_NOTCH: outsel = alu_res;
            default: outsel = '0;
        endcase
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg <= '0;
            band_reg <= '0;
        end else if (fire) begin
            if (ctl.dst == D_LOW) begin
                low_reg <= alu_res;
            end
            if (ctl.dst == D_BAND) begin
                band_reg <= alu_res;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= sample_in;
        end
        if (fire) begin
            unique case (ctl.dst)
                D_HIGH: high_reg <= alu_res;
                D_TMP: tmp_reg <= alu_res;
                D_ACC: acc_reg <= alu_res;
                D_HALF: half_reg <= alu_res;
                D_OUT: out_reg <= alu_res;
                D_OUTSEL: out_reg <= outsel;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && ctl.done) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blocked = out_valid_reg && !out_ready;
    assign mix_mode = (mode_reg == MODE_MIX);
    assign sample_out = out_reg;

endmodule

// ----- tb/tb_state_variable_filter_q31.sv -----
// tb_state_variable_filter_q31: self-checking testbench of the Q1.31 state-variable filter
// predicts every filtered sample with its own bit-true filter model and checks it on the output
// depends on svf_pkg and state_variable_filter_q31
`timescale 1ns / 100ps

module tb_state_variable_filter_q31;
    import svf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    // the one register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    // highest mode code, the top three are unused
    localparam logic [2:0] MODE_SPARE_LAST = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;

    // stimulus and checking state
    logic [31:0]        samples_to_send[$];
    logic signed [31:0] filtered_due[$];
    logic signed [31:0] due_sample;
    logic               in_taken = 1'b0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 n_taken = 0;
    int                 n_matched = 0;
    int                 n_fail = 0;
    int                 cycle_count = 0;

    // filter model: registers and integrators
    logic [30:0]        r_cutoff = '0;
    logic [2:0]         r_mode = '0;
    logic signed [31:0] r_low_gain = '0;
    logic signed [31:0] r_high_gain = '0;
    logic signed [31:0] r_band_gain = '0;
    logic signed [31:0] r_notch_gain = '0;
    logic signed [31:0] svf_low = '0;
    logic signed [31:0] svf_band = '0;
    logic signed [31:0] svf_mant = '0;
    logic [4:0]         svf_shift = '0;

    state_variable_filter_q31 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] sample_in
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [31:0] sample_out
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // saturating Q1.31 arithmetic
    function automatic logic signed [31:0] clip_q31(input logic signed [63:0] v);
        if (v > Q31_MAX) begin
            return Q31_MAX;
        end else if (v < Q31_MIN) begin
            return Q31_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd31(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] s;
        s = a;
        s = s + b;
        return clip_q31(s);
    endfunction

    function automatic logic signed [31:0] qsub31(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] s;
        s = a;
        s = s - b;
        return clip_q31(s);
    endfunction

    // floor of the product over 2^31, saturated
    function automatic logic signed [31:0] qmul31(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a;
        p = p * b;
        return clip_q31(p >>> 31);
    endfunction

    // one pass of the two integrators, returns the high term
    function automatic logic signed [31:0] integrate_frame(input logic signed [31:0] x);
        logic signed [31:0] f;
        logic signed [31:0] damp;
        logic signed [31:0] high;
        f = {1'b0, r_cutoff};
        svf_low = qadd31(svf_low, qmul31(f, svf_band));
        damp = qmul31(svf_mant, svf_band) >>> svf_shift;
        high = qsub31(qsub31(x, damp), svf_low);
        svf_band = qadd31(svf_band, qmul31(f, high));
        return high;
    endfunction

    function automatic logic signed [31:0] weighted_mix(input logic signed [31:0] high);
        logic signed [31:0] notch;
        logic signed [31:0] acc;
        notch = qadd31(svf_low, high);
        acc = qmul31(svf_low, r_low_gain);
        acc = qadd31(acc, qmul31(high, r_high_gain));
        acc = qadd31(acc, qmul31(svf_band, r_band_gain));
        acc = qadd31(acc, qmul31(notch, r_notch_gain));
        return acc;
    endfunction

    // filtered output for one input sample under the current mode
    function automatic logic signed [31:0] filtered_sample(input logic signed [31:0] x);
        logic signed [31:0] high;
        logic signed [31:0] half_a;
        logic signed [31:0] half_b;
        logic signed [31:0] y;
        case (r_mode)
            MODE_HIGH: begin
                y = integrate_frame(x);
            end
            MODE_BAND: begin
                high = integrate_frame(x);
                y = svf_band;
            end
            MODE_LOW: begin
                high = integrate_frame(x);
                y = svf_low;
            end
            MODE_NOTCH: begin
                high = integrate_frame(x);
                y = qadd31(svf_low, high);
            end
            MODE_MIX: begin
                high = integrate_frame(x);
                half_a = weighted_mix(high) >>> 1;
                high = integrate_frame(x);
                half_b = weighted_mix(high) >>> 1;
                y = qadd31(half_a, half_b);
            end
            default: begin
                high = integrate_frame(x);
                y = '0;
            end
        endcase
        return y;
    endfunction

    // register write on the pins and in the model, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        logic [30:0] d;
        logic [4:0]  sh;
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_CUTOFF: begin
                r_cutoff = data[30:0];
            end
            REG_DAMPING: begin
                // normalise so that bit 30 of the mantissa is set
                d = data[30:0];
                sh = '0;
                if (d != '0) begin
                    while (!d[30]) begin
                        d = d << 1;
                        sh = sh + 1'b1;
                    end
                end
                svf_mant = {1'b0, d};
                svf_shift = sh;
            end
            REG_MODE: begin
                r_mode = data[2:0];
            end
            REG_LOW_GAIN: begin
                r_low_gain = data;
            end
            REG_HIGH_GAIN: begin
                r_high_gain = data;
            end
            REG_BAND_GAIN: begin
                r_band_gain = data;
            end
            REG_NOTCH_GAIN: begin
                r_notch_gain = data;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued sample has gone in and every result has come back
    task automatic wait_drained();
        @(posedge aclk);
        while (samples_to_send.size() != 0 || s_tvalid || n_taken != n_matched) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] random_sample();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = Q31_MAX;
            end
            1: begin
                v = Q31_MIN;
            end
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(0, 20);
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 5))
            0: return Q31_MIN;
            1: return Q31_MAX;
            default: return $urandom;
        endcase
    endfunction

    // random register setting for one phase
    task automatic configure_phase(input int p);
        logic [31:0] cut;
        logic [31:0] damp;
        logic [2:0]  mode;
        case ($urandom_range(0, 3))
            0: cut = $urandom;
            1: cut = $urandom_range(0, 32'h0800_0000);
            2: cut = 32'h7FFF_FFFF;
            default: cut = $urandom_range(0, 32'h0100_0000);
        endcase
        damp = ($urandom_range(0, 7) == 0) ? 32'h0 : ($urandom >> $urandom_range(0, 31));
        if (p <= MODE_MIX) begin
            mode = p[2:0];
        end else if ($urandom_range(0, 9) < 8) begin
            mode = 3'($urandom_range(MODE_HIGH, MODE_MIX));
        end else begin
            mode = 3'($urandom_range(MODE_MIX + 1, MODE_SPARE_LAST));
        end
        write_reg(REG_CUTOFF, cut);
        write_reg(REG_DAMPING, damp);
        write_reg(REG_MODE, {$urandom} & ~32'h7 | mode);
        write_reg(REG_LOW_GAIN, random_gain());
        write_reg(REG_HIGH_GAIN, random_gain());
        write_reg(REG_BAND_GAIN, random_gain());
        write_reg(REG_NOTCH_GAIN, random_gain());
    endtask

    // input driver: next sample once the current transaction is done
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (aresetn && samples_to_send.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata <= samples_to_send.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check results first, then predict for the accepted sample
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_due.size() == 0) begin
                $display("%0t: unexpected sample_out, expected none, got %h", $time, m_tdata);
                n_fail = n_fail + 1;
            end else begin
                due_sample = filtered_due.pop_front();
                n_matched <= n_matched + 1;
                if (m_tdata !== due_sample) begin
                    $display("%0t: sample_out mismatch, expected %h, got %h",
                             $time, due_sample, m_tdata);
                    n_fail = n_fail + 1;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            filtered_due.push_back(filtered_sample(s_tdata));
            n_taken <= n_taken + 1;
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus sequence
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 31;
        recv_stall_pct = 51;

        // reset settings: cutoff zero, so the high output is the sample itself
        samples_to_send.push_back(Q31_MAX);
        samples_to_send.push_back(Q31_MIN);
        samples_to_send.push_back(32'h0);
        samples_to_send.push_back(32'hFFFF_FFFF);
        samples_to_send.push_back(32'h1);
        wait_drained();

        // every mode once, with extreme coefficients
        for (int m = MODE_HIGH; m <= MODE_SPARE_LAST; m++) begin
            write_reg(REG_CUTOFF, (m == MODE_BAND) ? 32'h0
                                  : (m[0] ? 32'h1000_0000 : 32'hFFFF_FFFF));
            // zero damping, smallest and largest damping
            write_reg(REG_DAMPING, (m == MODE_HIGH) ? 32'h0
                                   : (m == MODE_BAND) ? 32'h1
                                   : (m == MODE_LOW) ? 32'h7FFF_FFFF : $urandom);
            write_reg(REG_MODE, m);
            if (m == MODE_MIX) begin
                // all gains at minus one to hit the minus one squared product
                write_reg(REG_LOW_GAIN, Q31_MIN);
                write_reg(REG_HIGH_GAIN, Q31_MIN);
                write_reg(REG_BAND_GAIN, Q31_MIN);
                write_reg(REG_NOTCH_GAIN, Q31_MIN);
                // index with no register behind it must change nothing
                write_reg(REG_NONE, $urandom);
                repeat (3) samples_to_send.push_back(Q31_MIN);
            end else begin
                write_reg(REG_LOW_GAIN, $urandom);
                write_reg(REG_HIGH_GAIN, $urandom);
                write_reg(REG_BAND_GAIN, $urandom);
                write_reg(REG_NOTCH_GAIN, $urandom);
                samples_to_send.push_back(Q31_MIN);
                samples_to_send.push_back(Q31_MAX);
            end
            wait_drained();
        end

        // random phases with changing idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 31;
                recv_stall_pct = 51;
            end else if (p < 6) begin
                send_idle_pct = 51;
                recv_stall_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            configure_phase(p);
            repeat (PHASE_ITEMS) samples_to_send.push_back(random_sample());
            wait_drained();
        end

        // let any stray result show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (filtered_due.size() != 0) begin
            $display("%0t: %0d filtered samples never arrived", $time, filtered_due.size());
            n_fail = n_fail + 1;
        end
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
